/* rtl/lmba_pkg.sv */
// Package for the log mel band accumulator: sizes, constants and types.
// Used by the interface files and every RTL module.
`default_nettype none
package lmba_pkg;
  localparam int NumBands = 64;
  localparam int FftSize = 2048;
  localparam int NumFreqs = FftSize / 2 + 1;
  localparam int StoreDepth = NumBands * NumFreqs;
  localparam int AddrW = $clog2(StoreDepth);
  localparam int BandW = 6;
  localparam int BinW = 12;
  localparam int WeightW = 24;
  localparam int SumW = 52;
  localparam int MagW = 16;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [SumW-1:0] FloorSum = 52'd168;
  localparam logic signed [15:0] FloorLog = -16'sd11789;
  localparam logic [29:0] Ln2Q30 = 30'd744261118;

  localparam logic OpWeight = 1'b0;
  localparam logic OpBin = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [BandW-1:0]  band_index;
    logic [BinW-1:0]   bin_index;
    logic [WeightW-1:0] weight_value;
    logic signed [15:0] real_part;
    logic signed [15:0] imag_part;
    logic              frame_end;
  } in_item_t;

  typedef struct packed {
    logic [BandW-1:0]   band_number;
    logic signed [15:0] log_energy;
    logic               last_band;
  } out_item_t;

  // Request and answer between the top level and the log unit.
  typedef struct packed {
    logic            start;
    logic [SumW-1:0] sum;
  } log_req_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] value;
  } log_rsp_t;
endpackage
`default_nettype wire

/* rtl/lmba_in_if.sv */
// Valid/ready channel interface for input items.
// Depends on lmba_pkg.
`default_nettype none
interface lmba_in_if;
  logic valid;
  logic ready;
  lmba_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/lmba_out_if.sv */
// Valid/ready channel interface for result items.
// Depends on lmba_pkg.
`default_nettype none
interface lmba_out_if;
  logic valid;
  logic ready;
  lmba_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/lmba_log_unit.sv */
// Iterative natural log in Q.10 of a 52-bit Q.24 sum.
// One squaring multiplier reused for twenty rounds; depends on lmba_pkg.
`default_nettype none
module lmba_log_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lmba_pkg::log_req_t req_i,
  output      lmba_pkg::log_rsp_t rsp_o
);
  import lmba_pkg::*;

  typedef enum logic [2:0] {
    LgIdle, LgNorm, LgSquare, LgFold, LgScale, LgRound
  } lg_state_e;

  lg_state_e        state_q;
  logic [SumW-1:0]  s_q;
  logic [5:0]       p_q;
  logic [31:0]      x_q;
  logic [63:0]      sq_q;
  logic [4:0]       round_q;
  logic [25:0]      l_q;
  logic [55:0]      u_q;
  logic signed [15:0] value_q;
  logic             done_q;

  logic [63:0] u_sum;
  logic [63:0] k_const;
  assign k_const = (64'd24 << 20) * {34'd0, Ln2Q30};
  assign u_sum = {8'd0, u_q} + (64'd1 << 39) + (64'd32768 << 40) - k_const;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LgIdle;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        LgIdle: begin
          if (req_i.start) begin
            s_q <= req_i.sum;
            p_q <= 6'd51;
            if (req_i.sum < FloorSum) begin
              value_q <= FloorLog;
              done_q  <= 1'b1;
            end else begin
              state_q <= LgNorm;
            end
          end
        end
        // Walk the leading one to the top, one bit a cycle.
        LgNorm: begin
          if (s_q[SumW-1]) begin
            if (p_q >= 6'd30) x_q <= {1'b0, s_q[SumW-1 -: 31]} >> 0;
            else x_q <= {1'b0, s_q[SumW-1 -: 31]};
            l_q     <= {p_q[4:0] == 5'd0 && p_q[5] ? p_q : p_q, 20'd0};
            round_q <= 5'd19;
            state_q <= LgSquare;
          end else begin
            s_q <= s_q << 1;
            p_q <= p_q - 6'd1;
          end
        end
        LgSquare: begin
          sq_q    <= x_q * x_q;
          state_q <= LgFold;
        end
        LgFold: begin
          if (sq_q[61]) begin
            x_q <= {1'b0, sq_q[61:31]};
            l_q[round_q] <= 1'b1;
          end else begin
            x_q <= sq_q[61:30];
          end
          if (round_q == 5'd0) state_q <= LgScale;
          else begin
            round_q <= round_q - 5'd1;
            state_q <= LgSquare;
          end
        end
        LgScale: begin
          u_q     <= l_q * Ln2Q30;
          state_q <= LgRound;
        end
        LgRound: begin
          value_q <= 16'(u_sum[63:40] - 24'd32768);
          done_q  <= 1'b1;
          state_q <= LgIdle;
        end
        default: state_q <= LgIdle;
      endcase
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = value_q;
endmodule
`default_nettype wire

/* rtl/log_mel_band_accumulator_core.sv */
// Top level of the log mel band accumulator.
// Depends on lmba_pkg, lmba_in_if, lmba_out_if and lmba_log_unit.
//
// Usage: requests arrive on in_if. A weight request (operation 0) writes one
// Q0.24 weight into the weight memory when band and bin are in range. A bin
// request (operation 1) first takes the magnitude by a bit-pair square root,
// then visits the bands in turn: a registered read of the weight and band
// sum memories, one shared multiply and one saturating add. A bin outside the
// spectrum skips the band pass. With frame_end set, each band sum then passes
// through the iterative log unit and goes out on out_if in band order with
// last_band on the final band; the sum is cleared as it is read. The block
// takes no request while an item is in work. A stalled receiver holds the
// result and the sequence. Reset clears the band sums through their valid
// bits; the weight memory is undefined until written.
`default_nettype none
module log_mel_band_accumulator_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lmba_in_if.sink   in_if,
  lmba_out_if.source out_if
);
  import lmba_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StSqrt, StRead, StMul, StAcc, StFetch, StLog, StWaitLog, StSend
  } st_e;

  st_e              state_q;
  logic [WeightW-1:0] wmem [StoreDepth];
  logic [WeightW-1:0] wrd_q;
  logic [SumW-1:0]  sums [NumBands];
  logic [SumW-1:0]  sum_rd_q;
  logic [NumBands-1:0] sum_vld_q;
  logic [AddrW-1:0] base_q;
  logic [BandW-1:0] band_q;
  logic             fend_q, add_q;
  logic [31:0]      v_q;
  logic [MagW-1:0]  res_q;
  logic [4:0]       it_q;
  logic [WeightW+MagW-1:0] prod_q;
  log_req_t         lreq;
  log_rsp_t         lrsp;
  out_item_t        out_q;
  logic             out_vld_q;

  logic [AddrW-1:0] waddr, raddr;
  logic [SumW:0]    acc_sum;
  logic [SumW-1:0]  acc_sat;
  logic [SumW-1:0]  cur_sum;
  logic signed [31:0] re_x, im_x;
  logic [31:0]      re2, im2;

  assign waddr = AddrW'(in_if.data.band_index * NumFreqs) + AddrW'(in_if.data.bin_index);
  assign raddr = AddrW'(band_q * NumFreqs) + base_q;
  assign cur_sum = sum_vld_q[band_q] ? sum_rd_q : '0;
  assign acc_sum = {1'b0, cur_sum} + {{(SumW-WeightW-MagW+1){1'b0}}, prod_q};
  assign acc_sat = acc_sum[SumW] ? SumMax : acc_sum[SumW-1:0];
  assign re_x = {{16{in_if.data.real_part[15]}}, in_if.data.real_part};
  assign im_x = {{16{in_if.data.imag_part[15]}}, in_if.data.imag_part};
  assign re2 = re_x * re_x;
  assign im2 = im_x * im_x;

  // Weight memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready && in_if.data.operation == OpWeight &&
        {1'b0, in_if.data.band_index} < (BandW+1)'(NumBands) &&
        in_if.data.bin_index < BinW'(NumFreqs))
      wmem[waddr] <= in_if.data.weight_value;
    wrd_q <= wmem[raddr];
  end

  // Band sums: written on accumulation, read through a register at band_q.
  always_ff @(posedge clk_i) begin
    if (state_q == StAcc)
      sums[band_q] <= acc_sat;
    sum_rd_q <= sums[band_q];
  end

  logic [17:0] cand;
  assign cand = {res_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      sum_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_if.valid && in_if.data.operation == OpBin) begin
            base_q <= AddrW'(in_if.data.bin_index);
            fend_q <= in_if.data.frame_end;
            add_q  <= in_if.data.bin_index < BinW'(NumFreqs);
            v_q    <= re2 + im2;
            res_q  <= '0;
            it_q   <= 5'd15;
            band_q <= '0;
            state_q <= StSqrt;
          end
        end
        // Restoring square root, one result bit a cycle.
        StSqrt: begin
          if ({14'd0, cand} <= (v_q >> {it_q, 1'b0}) ) begin
            v_q   <= v_q - ({14'd0, cand} << {it_q, 1'b0});
            res_q <= {res_q[MagW-2:0], 1'b1};
          end else begin
            res_q <= {res_q[MagW-2:0], 1'b0};
          end
          if (it_q == 5'd0) state_q <= add_q ? StRead : (fend_q ? StFetch : StIdle);
          else it_q <= it_q - 5'd1;
        end
        StRead: state_q <= StMul;
        StMul: begin
          prod_q  <= wrd_q * res_q;
          state_q <= StAcc;
        end
        StAcc: begin
          sum_vld_q[band_q] <= 1'b1;
          if (band_q == BandW'(NumBands - 1)) begin
            band_q  <= '0;
            state_q <= fend_q ? StFetch : StIdle;
          end else begin
            band_q  <= band_q + 1'b1;
            state_q <= StRead;
          end
        end
        // StFetch lets the registered band sum memory read settle before the log request.
        StFetch: state_q <= StLog;
        StLog: begin
          sum_vld_q[band_q] <= 1'b0;
          state_q <= StWaitLog;
        end
        StWaitLog: begin
          if (lrsp.done) begin
            out_q.band_number <= band_q;
            out_q.log_energy  <= lrsp.value;
            out_q.last_band   <= band_q == BandW'(NumBands - 1);
            out_vld_q <= 1'b1;
            state_q   <= StSend;
          end
        end
        StSend: begin
          if (out_if.ready) begin
            out_vld_q <= 1'b0;
            if (band_q == BandW'(NumBands - 1)) begin
              band_q  <= '0;
              state_q <= StIdle;
            end else begin
              band_q  <= band_q + 1'b1;
              state_q <= StFetch;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign lreq.start = state_q == StLog;
  assign lreq.sum   = cur_sum;

  lmba_log_unit u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lreq),
    .rsp_o  (lrsp)
  );

  assign in_if.ready  = state_q == StIdle;
  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

`ifndef SYNTHESIS
  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_if.ready) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_if.ready |=> out_vld_q && $stable(out_q)) else $error("result dropped");
  a_valid_only_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> state_q == StSend) else $error("result outside send");
`endif
endmodule
`default_nettype wire
